FILE: rtl/core/assert_macros.svh
// assertion macros used by the port-level checker file
// no dependencies; expects clk and arst_n in the using scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define BGR_AST_IMPLY(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define BGR_AST_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

FILE: rtl/core/bgr_pkg.sv
// shared widths, register indexes and payload types for the rank remap block
// no dependencies
package bgr_pkg;

	localparam int NODE_W     = 20;
	localparam int CFG_W      = 10;
	localparam int DIMS_W     = 2;
	localparam int IDX_W      = 3;
	localparam int RANK_W     = 30;
	localparam int COORD_BITS = 10;
	localparam int DIV_W      = NODE_W + 1;

	localparam logic [DIV_W-1:0]  DIV_PASS  = DIV_W'(1) << NODE_W;
	localparam logic [DIMS_W-1:0] DIMS_2D   = 2'd2;
	localparam logic [DIMS_W-1:0] DIMS_3D   = 2'd3;
	localparam longint COORD_MAX = (64'd1 << COORD_BITS) - 64'd1;
	localparam longint RANK_MAX  = (64'd1 << RANK_W) - 64'd1;

	typedef enum logic [IDX_W-1:0] {
		REG_NUM_DIMS = 3'd0,
		REG_GRID_0   = 3'd1,
		REG_GRID_1   = 3'd2,
		REG_BLOCK_0  = 3'd3,
		REG_BLOCK_1  = 3'd4,
		REG_BLOCK_2  = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [NODE_W-1:0] node_number;
		logic [NODE_W-1:0] slot_in_node;
	} req_t;

	typedef struct packed {
		logic [COORD_BITS-1:0] coord_x;
		logic [COORD_BITS-1:0] coord_y;
		logic [COORD_BITS-1:0] coord_z;
		logic [RANK_W-1:0]     linear_rank;
		logic                  map_error;
	} rsp_t;

	// derived settings handed from the config unit to the datapath
	typedef struct packed {
		logic [CFG_W-1:0]   b0;
		logic [CFG_W-1:0]   b1;
		logic [CFG_W-1:0]   b2;
		logic [CFG_W-1:0]   g0;
		logic [2*CFG_W-1:0] g01;
		logic [CFG_W-1:0]   w;
		logic [DIV_W-1:0]   div_a;
		logic [DIV_W-1:0]   div_p;
		logic               err;
	} cfg_t;

endpackage

FILE: rtl/core/bgr_cfg.sv
// configuration registers and serial derivation of the per-item divisors
// depends on bgr_pkg
module bgr_cfg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [bgr_pkg::IDX_W-1:0]   cfg_index,
	input  logic [bgr_pkg::CFG_W-1:0]   cfg_data,
	output bgr_pkg::cfg_t               cur
);

	localparam int CW  = bgr_pkg::CFG_W;
	localparam int CNW = $clog2(CW);

	typedef enum logic [2:0] {
		ST_IDLE, ST_LOAD_W, ST_CALC_W, ST_LOAD_H, ST_CALC_H, ST_MULT
	} state_t;

	state_t                      state_q;
	logic [bgr_pkg::DIMS_W-1:0]  dims_q;
	logic [CW-1:0]               g0_q, g1_q, b0_q, b1_q, b2_q;
	logic [CW-1:0]               w_q, h_q, rem_q, dq_q;
	logic [CNW-1:0]              cnt_q;
	bgr_pkg::cfg_t               cur_q;

	logic [CW-1:0] div_d;
	logic [CW:0]   t, diff;
	logic          ge;
	logic [CW-1:0] rem_nx, dq_nx;
	logic [2*CW-1:0] prod_a, prod_p;

	// one restoring step, shared by both divisions
	always_comb begin
		div_d  = (state_q == ST_CALC_W) ? b1_q : b0_q;
		t      = {rem_q, dq_q[CW-1]};
		diff   = t - {1'b0, div_d};
		ge     = t >= {1'b0, div_d};
		rem_nx = ge ? diff[CW-1:0] : t[CW-1:0];
		dq_nx  = {dq_q[CW-2:0], ge};
		prod_a = w_q * h_q;
		prod_p = b0_q * b1_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			dims_q    <= bgr_pkg::DIMS_2D;
			g0_q      <= CW'(1);
			g1_q      <= CW'(1);
			b0_q      <= CW'(1);
			b1_q      <= CW'(1);
			b2_q      <= CW'(1);
			w_q       <= CW'(1);
			h_q       <= CW'(1);
			rem_q     <= '0;
			dq_q      <= '0;
			cnt_q     <= '0;
			cur_q.b0  <= CW'(1);
			cur_q.b1  <= CW'(1);
			cur_q.b2  <= CW'(1);
			cur_q.g0  <= CW'(1);
			cur_q.g01 <= (2*CW)'(1);
			cur_q.w   <= CW'(1);
			cur_q.div_a <= bgr_pkg::DIV_PASS;
			cur_q.div_p <= bgr_pkg::DIV_PASS;
			cur_q.err <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cfg_valid) begin
						case (cfg_index)
							bgr_pkg::REG_NUM_DIMS: dims_q <= cfg_data[bgr_pkg::DIMS_W-1:0];
							bgr_pkg::REG_GRID_0:   g0_q <= cfg_data;
							bgr_pkg::REG_GRID_1:   g1_q <= cfg_data;
							bgr_pkg::REG_BLOCK_0:  b0_q <= cfg_data;
							bgr_pkg::REG_BLOCK_1:  b1_q <= cfg_data;
							bgr_pkg::REG_BLOCK_2:  b2_q <= cfg_data;
							default: ;
						endcase
						state_q <= ST_LOAD_W;
					end
				end
				ST_LOAD_W: begin
					rem_q   <= '0;
					dq_q    <= g1_q;
					cnt_q   <= '0;
					state_q <= ST_CALC_W;
				end
				ST_CALC_W: begin
					rem_q <= rem_nx;
					dq_q  <= dq_nx;
					cnt_q <= cnt_q + CNW'(1);
					if (cnt_q == CNW'(CW - 1)) begin
						w_q     <= dq_nx;
						state_q <= ST_LOAD_H;
					end
				end
				ST_LOAD_H: begin
					rem_q   <= '0;
					dq_q    <= g0_q;
					cnt_q   <= '0;
					state_q <= ST_CALC_H;
				end
				ST_CALC_H: begin
					rem_q <= rem_nx;
					dq_q  <= dq_nx;
					cnt_q <= cnt_q + CNW'(1);
					if (cnt_q == CNW'(CW - 1)) begin
						h_q     <= dq_nx;
						state_q <= ST_MULT;
					end
				end
				ST_MULT: begin
					cur_q.b0  <= b0_q;
					cur_q.b1  <= b1_q;
					cur_q.b2  <= b2_q;
					cur_q.g0  <= g0_q;
					cur_q.g01 <= g0_q * g1_q;
					cur_q.w   <= w_q;
					if (dims_q == bgr_pkg::DIMS_3D) begin
						cur_q.div_a <= {1'b0, prod_a};
						cur_q.div_p <= {1'b0, prod_p};
					end else begin
						cur_q.div_a <= bgr_pkg::DIV_PASS;
						cur_q.div_p <= bgr_pkg::DIV_PASS;
					end
					cur_q.err <= (dims_q < bgr_pkg::DIMS_2D) || (b1_q == '0) || (w_q == '0)
						|| ((dims_q == bgr_pkg::DIMS_3D) && ((b0_q == '0) || (h_q == '0)));
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign cfg_ready = (state_q == ST_IDLE);
	assign cur       = cur_q;

endmodule

FILE: rtl/core/bgr_div_cell.sv
// one restoring division cell on two lanes, registered, with elastic handshake
// depends on bgr_pkg
module bgr_div_cell #(
	parameter int VW = bgr_pkg::DIV_W,
	parameter int DW = bgr_pkg::NODE_W,
	parameter int SW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          up_valid,
	output logic          up_ready,
	input  logic [VW-1:0] up_rem_n,
	input  logic [DW-1:0] up_dq_n,
	input  logic [VW-1:0] up_rem_s,
	input  logic [DW-1:0] up_dq_s,
	input  logic [SW-1:0] up_side,
	input  logic [VW-1:0] div_n,
	input  logic [VW-1:0] div_s,
	output logic          dn_valid,
	input  logic          dn_ready,
	output logic [VW-1:0] dn_rem_n,
	output logic [DW-1:0] dn_dq_n,
	output logic [VW-1:0] dn_rem_s,
	output logic [DW-1:0] dn_dq_s,
	output logic [SW-1:0] dn_side
);

	function automatic logic [VW+DW-1:0] div_step(input logic [VW-1:0] rem,
			input logic [DW-1:0] dq, input logic [VW-1:0] d);
		logic [VW:0] t;
		logic [VW:0] diff;
		logic        ge;
		t    = {rem, dq[DW-1]};
		diff = t - {1'b0, d};
		ge   = t >= {1'b0, d};
		return {(ge ? diff[VW-1:0] : t[VW-1:0]), dq[DW-2:0], ge};
	endfunction

	logic          v_q;
	logic [VW-1:0] rem_n_q, rem_s_q;
	logic [DW-1:0] dq_n_q, dq_s_q;
	logic [SW-1:0] side_q;

	assign up_ready = !v_q || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (up_ready) begin
			v_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			{rem_n_q, dq_n_q} <= div_step(up_rem_n, up_dq_n, div_n);
			{rem_s_q, dq_s_q} <= div_step(up_rem_s, up_dq_s, div_s);
			side_q            <= up_side;
		end
	end

	assign dn_valid = v_q;
	assign dn_rem_n = rem_n_q;
	assign dn_dq_n  = dq_n_q;
	assign dn_rem_s = rem_s_q;
	assign dn_dq_s  = dq_s_q;
	assign dn_side  = side_q;

endmodule

FILE: rtl/core/bgr_div_chain.sv
// row of division cells, one quotient bit per cell, node and slot lanes in step
// depends on bgr_pkg and bgr_div_cell
module bgr_div_chain #(
	parameter int VW = bgr_pkg::DIV_W,
	parameter int DW = bgr_pkg::NODE_W,
	parameter int SW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          up_valid,
	output logic          up_ready,
	input  logic [DW-1:0] up_dvd_n,
	input  logic [DW-1:0] up_dvd_s,
	input  logic [SW-1:0] up_side,
	input  logic [VW-1:0] div_n,
	input  logic [VW-1:0] div_s,
	output logic          dn_valid,
	input  logic          dn_ready,
	output logic [DW-1:0] dn_quo_n,
	output logic [VW-1:0] dn_rem_n,
	output logic [DW-1:0] dn_quo_s,
	output logic [VW-1:0] dn_rem_s,
	output logic [SW-1:0] dn_side
);

	logic          v   [0:DW];
	logic          rdy [0:DW];
	logic [VW-1:0] rn  [0:DW];
	logic [VW-1:0] rs  [0:DW];
	logic [DW-1:0] qn  [0:DW];
	logic [DW-1:0] qs  [0:DW];
	logic [SW-1:0] sd  [0:DW];

	assign v[0]    = up_valid;
	assign rn[0]   = '0;
	assign rs[0]   = '0;
	assign qn[0]   = up_dvd_n;
	assign qs[0]   = up_dvd_s;
	assign sd[0]   = up_side;
	assign up_ready = rdy[0];
	assign rdy[DW] = dn_ready;

	for (genvar i = 0; i < DW; i++) begin : g_cell
		bgr_div_cell #(.VW(VW), .DW(DW), .SW(SW)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (v[i]),
			.up_ready (rdy[i]),
			.up_rem_n (rn[i]),
			.up_dq_n  (qn[i]),
			.up_rem_s (rs[i]),
			.up_dq_s  (qs[i]),
			.up_side  (sd[i]),
			.div_n    (div_n),
			.div_s    (div_s),
			.dn_valid (v[i+1]),
			.dn_ready (rdy[i+1]),
			.dn_rem_n (rn[i+1]),
			.dn_dq_n  (qn[i+1]),
			.dn_rem_s (rs[i+1]),
			.dn_dq_s  (qs[i+1]),
			.dn_side  (sd[i+1])
		);
	end

	assign dn_valid = v[DW];
	assign dn_quo_n = qn[DW];
	assign dn_rem_n = rn[DW];
	assign dn_quo_s = qs[DW];
	assign dn_rem_s = rs[DW];
	assign dn_side  = sd[DW];

endmodule

FILE: rtl/core/bgr_post.sv
// coordinate assembly, range checks and rank sum over four elastic stages
// depends on bgr_pkg
module bgr_post (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          up_valid,
	output logic                          up_ready,
	input  logic                          err_in,
	input  logic [bgr_pkg::NODE_W-1:0]    qa_n,
	input  logic [bgr_pkg::NODE_W-1:0]    qa_s,
	input  logic [bgr_pkg::NODE_W-1:0]    qb_n,
	input  logic [bgr_pkg::CFG_W-1:0]     rb_n,
	input  logic [bgr_pkg::NODE_W-1:0]    qb_s,
	input  logic [bgr_pkg::CFG_W-1:0]     rb_s,
	input  bgr_pkg::cfg_t                 cur,
	output logic                          rsp_valid,
	input  logic                          rsp_stall,
	output bgr_pkg::rsp_t                 rsp
);

	localparam int NW    = bgr_pkg::NODE_W;
	localparam int CW    = bgr_pkg::CFG_W;
	localparam int KB    = bgr_pkg::COORD_BITS;
	localparam int XW    = NW + CW + 1;
	localparam int YW    = 2 * CW + 1;
	localparam int SUM_W = 2 * CW + KB + 2;

	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy1, rdy2, rdy3, rdy4;

	logic [NW+CW-1:0] mx_s1, mz_s1;
	logic [2*CW-1:0]  my_s1;
	logic [NW-1:0]    qbs_s1, qas_s1;
	logic [CW-1:0]    rbs_s1;
	logic             err_s1;

	logic [KB-1:0]    x_s2, y_s2, z_s2;
	logic             err_s2;

	logic [KB-1:0]    x_s3, y_s3, z_s3;
	logic [CW+KB-1:0] ry_s3;
	logic [2*CW+KB-1:0] rz_s3;
	logic             err_s3;

	bgr_pkg::rsp_t    rsp_s4;

	logic [XW-1:0]    x_full, z_full;
	logic [YW-1:0]    y_full;
	logic             range_err;
	logic [SUM_W-1:0] sum;
	logic             err4;

	assign rdy4     = !v_s4 || !rsp_stall;
	assign rdy3     = !v_s3 || rdy4;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign up_ready = rdy1;

	always_comb begin
		x_full    = {1'b0, mx_s1} + XW'(qbs_s1);
		y_full    = {1'b0, my_s1} + YW'(rbs_s1);
		z_full    = {1'b0, mz_s1} + XW'(qas_s1);
		range_err = (x_full > XW'(bgr_pkg::COORD_MAX)) || (y_full > YW'(bgr_pkg::COORD_MAX))
			|| (z_full > XW'(bgr_pkg::COORD_MAX));
		sum  = SUM_W'(x_s3) + SUM_W'(ry_s3) + SUM_W'(rz_s3);
		err4 = err_s3 || (sum > SUM_W'(bgr_pkg::RANK_MAX));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= up_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && up_valid) begin
			mx_s1  <= qb_n * cur.b0;
			my_s1  <= rb_n * cur.b1;
			mz_s1  <= qa_n * cur.b2;
			qbs_s1 <= qb_s;
			rbs_s1 <= rb_s;
			qas_s1 <= qa_s;
			err_s1 <= err_in;
		end
		if (rdy2 && v_s1) begin
			x_s2   <= x_full[KB-1:0];
			y_s2   <= y_full[KB-1:0];
			z_s2   <= z_full[KB-1:0];
			err_s2 <= err_s1 || range_err;
		end
		if (rdy3 && v_s2) begin
			ry_s3  <= cur.g0 * y_s2;
			rz_s3  <= cur.g01 * z_s2;
			x_s3   <= x_s2;
			y_s3   <= y_s2;
			z_s3   <= z_s2;
			err_s3 <= err_s2;
		end
		if (rdy4 && v_s3) begin
			rsp_s4.coord_x     <= err4 ? '0 : x_s3;
			rsp_s4.coord_y     <= err4 ? '0 : y_s3;
			rsp_s4.coord_z     <= err4 ? '0 : z_s3;
			rsp_s4.linear_rank <= err4 ? '0 : sum[bgr_pkg::RANK_W-1:0];
			rsp_s4.map_error   <= err4;
		end
	end

	assign rsp_valid = v_s4;
	assign rsp       = rsp_s4;

endmodule

FILE: rtl/core/blocked_grid_rank_remap.sv
// response path of 44 register stages: two 20-cell divider rows and 4 post stages
// throughput: one transaction per cycle while no config update or response stall holds it,
// and each divider cell settles one quotient bit per cycle
// a config write makes the block busy while the serial divider derives w and h
// arst_n clears all valid flags and loads the register reset values with divisors ready
// a stalled response freezes only the stages behind it; empty stages still fill
module blocked_grid_rank_remap (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_stall,
	input  bgr_pkg::req_t                 req,
	output logic                          rsp_valid,
	input  logic                          rsp_stall,
	output bgr_pkg::rsp_t                 rsp,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [bgr_pkg::IDX_W-1:0]     cfg_index,
	input  logic [bgr_pkg::CFG_W-1:0]     cfg_data
);

	localparam int NW = bgr_pkg::NODE_W;
	localparam int CW = bgr_pkg::CFG_W;
	localparam int VW = bgr_pkg::DIV_W;

	bgr_pkg::cfg_t cur;

	// first row: node by a (or pass-through in 2-D), slot by p
	logic          a_ready;
	logic          a_valid_out, a_ready_out;
	logic [NW-1:0] qa_n, qa_s;
	logic [VW-1:0] ra_n, ra_s;
	logic          a_err;

	// second row: node remainder by w, slot remainder by block_size_1
	logic          b_valid_out, b_ready_out;
	logic [NW-1:0] qb_n, qb_s;
	logic [CW-1:0] rb_n, rb_s;
	logic [2*NW:0] b_side;

	// derived divisors and the error bit are held here
	bgr_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cur       (cur)
	);

	// no transaction while the divisors are being recomputed
	assign req_stall = !cfg_ready || !a_ready;

	bgr_div_chain #(.VW(VW), .DW(NW), .SW(1)) u_row_a (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (req_valid && cfg_ready),
		.up_ready (a_ready),
		.up_dvd_n (req.node_number),
		.up_dvd_s (req.slot_in_node),
		.up_side  (cur.err),
		.div_n    (cur.div_a),
		.div_s    (cur.div_p),
		.dn_valid (a_valid_out),
		.dn_ready (a_ready_out),
		.dn_quo_n (qa_n),
		.dn_rem_n (ra_n),
		.dn_quo_s (qa_s),
		.dn_rem_s (ra_s),
		.dn_side  (a_err)
	);

	// remainders of the first row stay below 2**20, so the top bit drops
	bgr_div_chain #(.VW(CW), .DW(NW), .SW(2*NW+1)) u_row_b (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (a_valid_out),
		.up_ready (a_ready_out),
		.up_dvd_n (ra_n[NW-1:0]),
		.up_dvd_s (ra_s[NW-1:0]),
		.up_side  ({a_err, qa_n, qa_s}),
		.div_n    (cur.w),
		.div_s    (cur.b1),
		.dn_valid (b_valid_out),
		.dn_ready (b_ready_out),
		.dn_quo_n (qb_n),
		.dn_rem_n (rb_n),
		.dn_quo_s (qb_s),
		.dn_rem_s (rb_s),
		.dn_side  (b_side)
	);

	// x, y, z, range checks, rank and the response register
	bgr_post u_post (
		.clk       (clk),
		.arst_n    (arst_n),
		.up_valid  (b_valid_out),
		.up_ready  (b_ready_out),
		.err_in    (b_side[2*NW]),
		.qa_n      (b_side[2*NW-1:NW]),
		.qa_s      (b_side[NW-1:0]),
		.qb_n      (qb_n),
		.rb_n      (rb_n),
		.qb_s      (qb_s),
		.rb_s      (rb_s),
		.cur       (cur),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

FILE: rtl/core/bgr_checker.sv
// port-level checks for the rank remap block and their bind
// depends on bgr_pkg and assert_macros.svh
`include "assert_macros.svh"

module bgr_props (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          req_valid,
	input logic                          req_stall,
	input bgr_pkg::req_t                 req,
	input logic                          rsp_valid,
	input logic                          rsp_stall,
	input bgr_pkg::rsp_t                 rsp,
	input logic                          cfg_valid,
	input logic                          cfg_ready,
	input logic [bgr_pkg::IDX_W-1:0]     cfg_index,
	input logic [bgr_pkg::CFG_W-1:0]     cfg_data
);

	logic rsp_zero;

	// every field but the flag is zero
	assign rsp_zero = (rsp.coord_x == '0) && (rsp.coord_y == '0) && (rsp.coord_z == '0)
		&& (rsp.linear_rank == '0);

	`BGR_AST_NEXT(a_cfg_busy, cfg_valid && cfg_ready, req_stall && !cfg_ready)
	`BGR_AST_IMPLY(a_busy_stall, !cfg_ready, req_stall)
	`BGR_AST_IMPLY(a_err_zero, rsp_valid && rsp.map_error, rsp_zero)
	`BGR_AST_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))

endmodule

bind blocked_grid_rank_remap bgr_props u_bgr_props (.*);

FILE: tb/bgr_checker.sv
// response checker for blocked_grid_rank_remap: mirrors the register file,
// predicts every response and compares it with what the block returns
// depends on bgr_pkg for the payload types and register indexes
module bgr_checker (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      req_valid,
	input  logic                      req_stall,
	input  bgr_pkg::req_t             req,
	input  logic                      rsp_valid,
	input  logic                      rsp_stall,
	input  bgr_pkg::rsp_t             rsp,
	input  logic                      cfg_valid,
	input  logic                      cfg_ready,
	input  logic [bgr_pkg::IDX_W-1:0] cfg_index,
	input  logic [bgr_pkg::CFG_W-1:0] cfg_data,
	output int                        mismatches,
	output int                        outstanding,
	output int                        checked
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DW = bgr_pkg::DIMS_W;
	localparam int CW = bgr_pkg::CFG_W;

	logic [DW-1:0]   dims;
	logic [CW-1:0]   g0, g1, b0, b1, b2;
	bgr_pkg::rsp_t   pending_rsp[$];

	function automatic bgr_pkg::rsp_t map_predict(input logic [DW-1:0] nd,
			input logic [CW-1:0] gx, gy, bx, by, bz, input bgr_pkg::req_t r);
		longint unsigned node, slot, x, y, z, rank, w, h, a, p, sn, ss;
		bit bad;
		bgr_pkg::rsp_t o;
		node = r.node_number;
		slot = r.slot_in_node;
		x = 0; y = 0; z = 0; rank = 0;
		bad = 0;
		if (nd < 2 || by == 0) begin
			bad = 1;
		end else begin
			w = gy / by;
			if (w == 0) begin
				bad = 1;
			end else if (nd == bgr_pkg::DIMS_2D) begin
				x = (node / w) * bx + slot / by;
				y = (node % w) * by + slot % by;
			end else if (bx == 0 || gx / bx == 0) begin
				bad = 1;
			end else begin
				h = gx / bx;
				a = w * h;
				p = bx * by;
				sn = node % a;
				ss = slot % p;
				z = (node / a) * bz + slot / p;
				x = (sn / w) * bx + ss / by;
				y = (sn % w) * by + ss % by;
			end
		end
		if (!bad && (x > bgr_pkg::COORD_MAX || y > bgr_pkg::COORD_MAX
				|| z > bgr_pkg::COORD_MAX))
			bad = 1;
		if (!bad) begin
			rank = x + gx * y + longint'(gx) * gy * z;
			if (rank > bgr_pkg::RANK_MAX)
				bad = 1;
		end
		o = '0;
		if (!bad) begin
			o.coord_x     = x[bgr_pkg::COORD_BITS-1:0];
			o.coord_y     = y[bgr_pkg::COORD_BITS-1:0];
			o.coord_z     = z[bgr_pkg::COORD_BITS-1:0];
			o.linear_rank = rank[bgr_pkg::RANK_W-1:0];
		end
		o.map_error = bad;
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		bgr_pkg::rsp_t want;
		if (!arst_n) begin
			dims <= bgr_pkg::DIMS_2D;
			g0 <= CW'(1); g1 <= CW'(1); b0 <= CW'(1); b1 <= CW'(1); b2 <= CW'(1);
			pending_rsp.delete();
			mismatches <= 0;
			outstanding <= 0;
			checked <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					bgr_pkg::REG_NUM_DIMS: dims <= cfg_data[DW-1:0];
					bgr_pkg::REG_GRID_0:   g0 <= cfg_data;
					bgr_pkg::REG_GRID_1:   g1 <= cfg_data;
					bgr_pkg::REG_BLOCK_0:  b0 <= cfg_data;
					bgr_pkg::REG_BLOCK_1:  b1 <= cfg_data;
					bgr_pkg::REG_BLOCK_2:  b2 <= cfg_data;
					default: ;
				endcase
			end
			if (rsp_valid && !rsp_stall) begin
				if (pending_rsp.size() == 0) begin
					if (mismatches < 10)
						$display("unexpected response %p", rsp);
					mismatches <= mismatches + 1;
				end else begin
					want = pending_rsp.pop_front();
					checked <= checked + 1;
					if (rsp.coord_x !== want.coord_x || rsp.coord_y !== want.coord_y ||
							rsp.coord_z !== want.coord_z ||
							rsp.linear_rank !== want.linear_rank ||
							rsp.map_error !== want.map_error) begin
						if (mismatches < 10)
							$display("mismatch: expected %p got %p", want, rsp);
						mismatches <= mismatches + 1;
					end
				end
			end
			if (req_valid && !req_stall)
				pending_rsp.push_back(map_predict(dims, g0, g1, b0, b1, b2, req));
			outstanding <= pending_rsp.size();
		end
	end

endmodule

FILE: tb/testbench.sv
// top of the rank remap testbench: clock, reset, stimulus and verdict
// depends on bgr_pkg, blocked_grid_rank_remap and bgr_checker
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int IW = bgr_pkg::IDX_W;
	localparam int CW = bgr_pkg::CFG_W;
	localparam int NW = bgr_pkg::NODE_W;

	localparam int LIMIT_CYCLES = 600000;
	localparam int DRAIN_CYCLES = 80;
	localparam int LONG_HOLD    = 400;
	// receiver stall patterns
	localparam int STALL_NONE  = 0;
	localparam int STALL_LIGHT = 1;
	localparam int STALL_HEAVY = 2;
	// indexes outside the register file
	localparam logic [IW-1:0] REG_SPARE_6 = 3'd6;
	localparam logic [IW-1:0] REG_SPARE_7 = 3'd7;

	typedef struct {
		logic [CW-1:0] nd, gx, gy, bx, by, bz;
		int            items;
	} grid_setting_t;

	logic             clk, arst_n;
	logic             req_valid, req_stall, rsp_valid, rsp_stall;
	logic             cfg_valid, cfg_ready;
	logic [IW-1:0]    cfg_index;
	logic [CW-1:0]    cfg_data;
	bgr_pkg::req_t    req;
	bgr_pkg::rsp_t    rsp;
	int               mismatches, outstanding, checked;
	int               cycles, sent, settings_run;
	logic             hold_go, hold_used;
	int               hold_left, stall_mode, mode_left;

	blocked_grid_rank_remap dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	bgr_checker chk (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.mismatches(mismatches), .outstanding(outstanding), .checked(checked)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// watchdog on total run length
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT_CYCLES) begin
			$display("testbench failed");
			$finish;
		end
	end

	// receiver side: changing stall patterns plus one long hold-off that fills the pipe
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_stall <= 0;
			hold_left <= 0;
			hold_used <= 0;
			stall_mode <= STALL_NONE;
			mode_left <= 0;
		end else if (hold_left != 0) begin
			rsp_stall <= 1;
			hold_left <= hold_left - 1;
		end else if (hold_go && !hold_used) begin
			rsp_stall <= 1;
			hold_left <= LONG_HOLD;
			hold_used <= 1;
		end else begin
			if (mode_left == 0) begin
				stall_mode <= $urandom_range(STALL_NONE, STALL_HEAVY);
				mode_left <= $urandom_range(16, 128);
			end else begin
				mode_left <= mode_left - 1;
			end
			case (stall_mode)
				STALL_NONE:  rsp_stall <= 0;
				STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
				default:     rsp_stall <= ($urandom_range(0, 3) != 0);
			endcase
		end
	end

	// offer one request and hold it until the block takes it; valid stays high afterwards
	task automatic offer_request(input logic [NW-1:0] node, input logic [NW-1:0] slot);
		req_valid <= 1;
		req.node_number <= node;
		req.slot_in_node <= slot;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		sent++;
	endtask

	task automatic write_reg(input logic [IW-1:0] idx, input logic [CW-1:0] val);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 0;
	endtask

	// drain the block, then program a whole grid setting
	task automatic apply_setting(input grid_setting_t s);
		req_valid <= 0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		// upper data bits of the dimensionality register are junk on purpose
		write_reg(bgr_pkg::REG_NUM_DIMS, {8'($urandom_range(0, 255)), s.nd[1:0]});
		write_reg(bgr_pkg::REG_GRID_0, s.gx);
		write_reg(bgr_pkg::REG_GRID_1, s.gy);
		write_reg(bgr_pkg::REG_BLOCK_0, s.bx);
		write_reg(bgr_pkg::REG_BLOCK_1, s.by);
		write_reg(bgr_pkg::REG_BLOCK_2, s.bz);
		if ($urandom_range(0, 1))
			write_reg(REG_SPARE_6, CW'($urandom()));
		else
			write_reg(REG_SPARE_7, CW'($urandom()));
		settings_run++;
	endtask

	// random requests in bursts; mostly small node numbers so mappings stay in range
	task automatic random_burst_run(input int count);
		int left, burst, gap, pick;
		logic [NW-1:0] node, slot;
		left = count;
		while (left > 0) begin
			burst = $urandom_range(1, 30);
			while (burst > 0 && left > 0) begin
				pick = $urandom_range(0, 9);
				if (pick < 6) begin
					node = NW'($urandom_range(0, 300));
					slot = NW'($urandom_range(0, 2000));
				end else if (pick < 8) begin
					node = NW'($urandom());
					slot = NW'($urandom());
				end else begin
					node = NW'($urandom_range(0, 40));
					slot = NW'($urandom());
				end
				offer_request(node, slot);
				burst--;
				left--;
			end
			gap = $urandom_range(0, 8);
			if (gap > 5) begin
				req_valid <= 0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic edge_requests();
		offer_request('0, '0);
		offer_request('1, '1);
		offer_request('0, '1);
		offer_request('1, '0);
		offer_request(20'd1, 20'd1);
		offer_request(20'h55555, 20'haaaaa);
	endtask

	grid_setting_t fixed_settings[$];
	grid_setting_t s;

	initial begin
		arst_n = 0;
		req_valid = 0;
		req = '0;
		cfg_valid = 0;
		cfg_index = bgr_pkg::REG_NUM_DIMS;
		cfg_data = '0;
		hold_go = 0;
		cycles = 0;
		sent = 0;
		settings_run = 0;
		// dims, g0, g1, b0, b1, b2, random items
		fixed_settings = '{
			'{2, 32, 32, 4, 4, 7, 80},          // plain 2-D
			'{3, 16, 16, 4, 4, 4, 120},         // plain 3-D
			'{3, 1023, 1023, 1023, 1023, 1023, 40},
			'{2, 1023, 1023, 1, 1, 0, 60},      // 2-D with unit blocks, third block ignored
			'{2, 1023, 1023, 1023, 1023, 5, 40},
			'{2, 20, 20, 4, 0, 3, 30},          // zero second block
			'{2, 20, 3, 4, 5, 3, 30},           // fewer columns than one block
			'{3, 20, 20, 0, 4, 3, 30},          // zero first block in 3-D
			'{3, 2, 20, 3, 4, 3, 30},           // fewer rows than one block in 3-D
			'{0, 20, 20, 4, 4, 4, 20},          // bad dimensionality
			'{1, 20, 20, 4, 4, 4, 20},
			'{3, 0, 0, 1, 1, 1, 20},
			'{3, 8, 8, 2, 2, 1023, 60}          // tall third block overflows z fast
		};
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// reset values first
		edge_requests();
		random_burst_run(30);
		foreach (fixed_settings[i]) begin
			apply_setting(fixed_settings[i]);
			if (i < 3)
				edge_requests();
			if (i == 1)
				hold_go <= 1;
			random_burst_run(fixed_settings[i].items);
		end
		// random settings, sizes mostly small, a zero now and then
		repeat (8) begin
			s.nd = CW'($urandom_range(2, 3));
			s.gx = ($urandom_range(0, 15) == 0) ? '0 : CW'($urandom_range(1, 64));
			s.gy = ($urandom_range(0, 15) == 0) ? '0 : CW'($urandom_range(1, 64));
			s.bx = ($urandom_range(0, 15) == 0) ? '0 : CW'($urandom_range(1, 16));
			s.by = ($urandom_range(0, 15) == 0) ? '0 : CW'($urandom_range(1, 16));
			s.bz = CW'($urandom_range(0, 1023));
			s.items = 140;
			apply_setting(s);
			random_burst_run(s.items);
		end

		req_valid <= 0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("%0d requests over %0d grid settings, %0d responses checked", sent,
			settings_run + 1, checked);
		$display("covered 2-D and 3-D maps, zero divisors, range overflow and long back-pressure");
		if (mismatches == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/bgr_pkg.sv
rtl/core/bgr_cfg.sv
rtl/core/bgr_div_cell.sv
rtl/core/bgr_div_chain.sv
rtl/core/bgr_post.sv
rtl/core/blocked_grid_rank_remap.sv
rtl/core/bgr_checker.sv
tb/bgr_checker.sv
tb/testbench.sv
